FILE: src/mru_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mru_pkg: shared types and constants for the mru page replacement block
// frame count, field widths and the structs passed along the frame chain
// ----------------------------------------------------------------------------
package mru_pkg;

  localparam int FRAMES  = 16;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int PAGE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int TOTAL_W = 16;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(16);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [PAGE_W-1:0] page_t;

  // per-frame control from the top level
  typedef struct packed {
    logic  active;
    logic  wr_en;
    page_t page;
  } cell_ctl_t;

  // running priority flags handed from frame to frame
  typedef struct packed {
    logic hit_seen;
    logic empty_seen;
  } cell_chain_t;

  // per-frame selection result
  typedef struct packed {
    logic hit_sel;
    logic empty_sel;
  } cell_stat_t;

endpackage

`default_nettype wire

FILE: src/mru_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mru_cell: one frame of the replacement table
// holds a page and its valid flag, compares against the looked-up page and
// passes the first-match and first-empty flags on to the next frame
// ----------------------------------------------------------------------------
module mru_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  mru_pkg::cell_ctl_t   ctl_i,
  input  mru_pkg::cell_chain_t chain_i,
  output mru_pkg::cell_chain_t chain_o,
  output mru_pkg::cell_stat_t  stat_o,
  output mru_pkg::page_t       page_o
);
  import mru_pkg::*;

  logic  valid_r, valid_nxt;
  page_t page_r, page_nxt;
  logic  match, empty;

  assign match = ctl_i.active && valid_r && (page_r == ctl_i.page);
  assign empty = ctl_i.active && !valid_r;

  assign chain_o.hit_seen   = chain_i.hit_seen || match;
  assign chain_o.empty_seen = chain_i.empty_seen || empty;
  assign stat_o.hit_sel     = match && !chain_i.hit_seen;
  assign stat_o.empty_sel   = empty && !chain_i.empty_seen;
  assign page_o             = page_r;

  always_comb begin
    valid_nxt = valid_r;
    page_nxt  = page_r;
    if (ctl_i.wr_en) begin
      valid_nxt = 1'b1;
      page_nxt  = ctl_i.page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    page_r <= page_nxt;
  end

endmodule

`default_nettype wire

FILE: src/mru_page_replacement.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mru_page_replacement: fully associative frame table with mru eviction
// one page reference per word in, one lookup result per word out
// ----------------------------------------------------------------------------
// Each input word is one page reference. It is checked against a row of
// FRAMES frame cells, of which only the lowest frames_in_use take part
// (0 counts as 1, anything above FRAMES counts as FRAMES). A hit reports the
// frame and bumps the hit total; a miss fills the lowest empty in-use frame,
// or when all are full replaces the frame used by the previous reference
// (frame 0 if that one has dropped out of the in-use range) and bumps the
// fault total. Both totals saturate at 65535. Each reference first has its
// page registered; then the frame chain compares in parallel, ripples the
// first-hit and first-empty flags from frame to frame, writes the chosen
// frame and loads the result word. A result that is stalled holds the chain
// until it is taken, and the input side stalls while a lookup is held.
// frames_in_use is written through cfg_ and is taken at any cycle, it should
// only change while no word is in flight.
// ----------------------------------------------------------------------------
module mru_page_replacement (
  input  wire                          clk,
  input  wire                          rst_n,
  // page reference words
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [mru_pkg::PAGE_W-1:0]   in_page,
  // lookup result words
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_hit,
  output logic [mru_pkg::SLOT_W-1:0]   out_slot,
  output logic                         out_evicted,
  output logic [mru_pkg::PAGE_W-1:0]   out_evicted_page,
  output logic [mru_pkg::TOTAL_W-1:0]  out_hit_total,
  output logic [mru_pkg::TOTAL_W-1:0]  out_fault_total,
  // frames_in_use register write
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [mru_pkg::CFG_W-1:0]    cfg_frames_in_use
);
  import mru_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t              state_r;
  page_t               page_r;
  logic [CFG_W-1:0]    frames_r;
  logic [IDX_W-1:0]    recent_r;
  logic [TOTAL_W-1:0]  hits_r, hits_nxt;
  logic [TOTAL_W-1:0]  faults_r, faults_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_evicted_r;
  page_t               out_evicted_page_r;

  logic [CNT_W-1:0]    n_eff;
  logic                in_take, go;

  cell_ctl_t           ctl    [FRAMES];
  cell_chain_t         chain  [FRAMES+1];
  cell_stat_t          stat   [FRAMES];
  page_t               cpage  [FRAMES];

  logic [FRAMES-1:0]   hit_vec, empty_vec, victim_vec, wr_oh;
  logic                any_hit, any_empty;
  logic [IDX_W-1:0]    victim_idx, hit_idx, empty_idx, slot_idx;

  // config register is always ready
  assign cfg_ready = 1'b1;

  // effective frame count, clamped to 1..FRAMES
  always_comb begin
    if (frames_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(frames_r) > FRAMES) begin
      n_eff = CNT_W'(FRAMES);
    end else begin
      n_eff = CNT_W'(frames_r);
    end
  end

  // a lookup runs once the previous result has left the output register
  assign in_stall = (state_r == S_LOOK);
  assign in_take  = in_valid && !in_stall;
  assign go       = (state_r == S_LOOK) && !(out_valid_r && out_stall);

  // result word stays while stalled, a finished lookup loads a new one
  assign out_valid_nxt = go || (out_valid_r && out_stall);

  // stale recent frame falls back to frame 0
  assign victim_idx = (32'(recent_r) < 32'(n_eff)) ? recent_r : '0;

  // frame chain
  assign chain[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_frame
    assign ctl[g].active = (g < 32'(n_eff));
    assign ctl[g].wr_en  = go && wr_oh[g];
    assign ctl[g].page   = page_r;

    mru_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[g]),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .stat_o  (stat[g]),
      .page_o  (cpage[g])
    );

    assign hit_vec[g]    = stat[g].hit_sel;
    assign empty_vec[g]  = stat[g].empty_sel;
    assign victim_vec[g] = (victim_idx == IDX_W'(g));
  end

  assign any_hit   = chain[FRAMES].hit_seen;
  assign any_empty = chain[FRAMES].empty_seen;

  // one-hot to index, at most one bit of each vector is set
  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (empty_vec[i]) begin
        empty_idx = empty_idx | IDX_W'(i);
      end
    end
  end

  // frame choice: hit, else lowest empty, else most recent
  always_comb begin
    priority if (any_hit) begin
      slot_idx = hit_idx;
      wr_oh    = '0;
    end else if (any_empty) begin
      slot_idx = empty_idx;
      wr_oh    = empty_vec;
    end else begin
      slot_idx = victim_idx;
      wr_oh    = victim_vec;
    end
  end

  // saturating totals
  always_comb begin
    hits_nxt   = hits_r;
    faults_nxt = faults_r;
    if (any_hit) begin
      if (hits_r != TOTAL_MAX) begin
        hits_nxt = hits_r + TOTAL_W'(1);
      end
    end else if (faults_r != TOTAL_MAX) begin
      faults_nxt = faults_r + TOTAL_W'(1);
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frames_r <= cfg_frames_in_use;
    end
  end

  // sequencer, table state and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      recent_r    <= '0;
      hits_r      <= '0;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (go) begin
            state_r     <= S_IDLE;
            recent_r    <= slot_idx;
            hits_r      <= hits_nxt;
            faults_r    <= faults_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (in_take) begin
      page_r <= in_page;
    end
    if (go) begin
      out_hit_r          <= any_hit;
      out_slot_r         <= SLOT_W'(32'(slot_idx));
      out_evicted_r      <= !any_hit && !any_empty;
      out_evicted_page_r <= (!any_hit && !any_empty) ? cpage[victim_idx] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_slot         = out_slot_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_evicted_page_r;
  assign out_hit_total    = hits_r;
  assign out_fault_total  = faults_r;

`ifndef SYNTHESIS
  // an accepted word always starts a lookup
  a_take_looks: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (state_r == S_LOOK))
    else $error("accepted word did not start a lookup");

  // at most one frame is written per lookup
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> $onehot0(wr_oh))
    else $error("more than one frame written");

  // the chain hands up exactly one first hit
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (go && any_hit) |-> $onehot(hit_vec))
    else $error("hit chain selected no or several frames");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("result reports both hit and eviction");
`endif

endmodule

`default_nettype wire
